/* hw/rtl/bfei_pkg.sv */
// Shared constants, codes and interface types for the bit field extract/insert block.
// Used by bfei_ctrl, bfei_dp and the top level bit_field_extract_insert.
package bfei_pkg;

	localparam int BUF_BYTES    = 256;
	localparam int MAX_GET_BITS = 64;
	localparam int MAX_SET_BITS = 32;

	localparam int ADDR_W   = $clog2(BUF_BYTES);
	localparam int BUF_BITS = BUF_BYTES * 8;
	localparam int WIN_BITS = MAX_SET_BITS + 8;          // set window, up to five bytes
	localparam int ACC_BITS = MAX_GET_BITS + 8;          // get gather, up to nine bytes
	localparam int MAX_SPAN = MAX_GET_BITS / 8 + 1;
	localparam int CNT_W    = $clog2(MAX_SPAN + 1);

	localparam logic [2:0] OP_WRITE_BYTE = 3'd0;
	localparam logic [2:0] OP_READ_BYTE  = 3'd1;
	localparam logic [2:0] OP_GET_U      = 3'd2;
	localparam logic [2:0] OP_GET_S      = 3'd3;
	localparam logic [2:0] OP_SET        = 3'd4;

	typedef enum logic [1:0] {
		K_NONE,
		K_WRITE,
		K_GET,
		K_SET
	} kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic setup;
		logic rd;
		logic adv;
		logic wr_byte;
		logic wr_merge;
		logic extract;
		logic sign;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		kind_t kind;
		logic  err;
		logic  last;
	} sts_t;

	// Ones in the low n bits, n up to 64
	function automatic logic [63:0] low_mask(input logic [6:0] n);
		return ~({64{1'b1}} << n);
	endfunction

endpackage

/* hw/rtl/bfei_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module bfei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* hw/rtl/bfei_dp.sv */
// Datapath: operand capture, request decode, byte gather, field extract and set merge.
// Depends on bfei_pkg; drives the buffer RAM port from the top level.
module bfei_dp
	import bfei_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [2:0]        opcode,
	input  logic [7:0]        byte_index,
	input  logic [7:0]        byte_value,
	input  logic [10:0]       bit_pos,
	input  logic [6:0]        field_len,
	input  logic [31:0]       set_value,
	output logic              ram_re,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_addr,
	output logic [7:0]        ram_wdata,
	input  logic [7:0]        ram_rdata,
	output logic [63:0]       read_value,
	output logic              error
);

	logic [2:0]  op_q;
	logic [7:0]  bidx_q;
	logic [7:0]  bval_q;
	logic [10:0] pos_q;
	logic [6:0]  len_q;
	logic [31:0] data_q;

	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [2:0]          tail_q;
	logic [6:0]          elen_q;
	logic                sgn_q;
	logic [WIN_BITS-1:0] dwin_q;
	logic [WIN_BITS-1:0] mwin_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [63:0]         res_q;
	logic [BUF_BYTES-1:0] valid_q;
	logic                rd_s1;
	logic                rvalid_s1;
	logic [63:0]         out_data_q;
	logic                out_err_q;

	// Decode
	kind_t       kind_d;
	logic        err_d;
	logic [11:0] end_w;
	logic [11:0] last_bit;
	logic        fits;
	logic        byte_ok;
	logic [63:0] len_mask;
	logic [31:0] m32;
	logic [5:0]  win_sh;
	logic [11:0] span;

	assign end_w    = {1'b0, pos_q} + 12'(len_q);
	assign last_bit = end_w - 12'd1;
	assign fits     = 32'(end_w) <= 32'(BUF_BITS);
	assign byte_ok  = 32'(bidx_q) < 32'(BUF_BYTES);
	assign len_mask = low_mask(len_q);
	assign m32      = len_mask[31:0];
	assign win_sh   = 6'(WIN_BITS) - 6'(pos_q[2:0]) - 6'(len_q);
	assign span     = (last_bit >> 3) - ({1'b0, pos_q} >> 3) + 12'd1;

	always_comb begin
		kind_d = K_NONE;
		err_d  = 1'b0;
		unique case (op_q) inside
			OP_WRITE_BYTE: begin
				kind_d = K_WRITE;
				err_d  = !byte_ok;
			end
			OP_READ_BYTE: begin
				kind_d = K_GET;
				err_d  = !byte_ok;
			end
			OP_GET_U, OP_GET_S: begin
				kind_d = K_GET;
				err_d  = (len_q == 7'd0) || (32'(len_q) > 32'(MAX_GET_BITS)) || !fits;
			end
			OP_SET: begin
				kind_d = K_SET;
				err_d  = (len_q == 7'd0) || (32'(len_q) > 32'(MAX_SET_BITS)) || !fits;
			end
			default: begin
				kind_d = K_NONE;
				err_d  = 1'b0;
			end
		endcase
	end

	assign sts.kind = kind_d;
	assign sts.err  = err_d;
	assign sts.last = (cnt_q == CNT_W'(1));

	// Read data of a byte never written since reset is zero
	logic [7:0]          rbyte;
	logic [7:0]          merged;
	logic [ACC_BITS-1:0] acc_sh;
	logic [63:0]         emask;
	logic [5:0]          sbit;

	assign rbyte  = rvalid_s1 ? ram_rdata : 8'd0;
	assign merged = (rbyte & ~mwin_q[WIN_BITS-1 -: 8]) |
		(dwin_q[WIN_BITS-1 -: 8] & mwin_q[WIN_BITS-1 -: 8]);
	assign acc_sh = acc_q >> tail_q;
	assign emask  = low_mask(elen_q);
	assign sbit   = 6'(elen_q - 7'd1);

	assign ram_re    = cmd.rd;
	assign ram_we    = cmd.wr_byte || cmd.wr_merge;
	assign ram_addr  = addr_q;
	assign ram_wdata = cmd.wr_byte ? bval_q : merged;

	// Operand capture and work registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			bidx_q <= byte_index;
			bval_q <= byte_value;
			pos_q  <= bit_pos;
			len_q  <= field_len;
			data_q <= set_value;
		end
		if (cmd.setup) begin
			res_q  <= '0;
			acc_q  <= '0;
			dwin_q <= WIN_BITS'({8'd0, data_q & m32}) << win_sh;
			mwin_q <= WIN_BITS'(m32) << win_sh;
			sgn_q  <= (op_q == OP_GET_S);
			if (op_q == OP_READ_BYTE || op_q == OP_WRITE_BYTE) begin
				addr_q <= ADDR_W'(bidx_q);
				cnt_q  <= CNT_W'(1);
				tail_q <= 3'd0;
				elen_q <= 7'd8;
			end else begin
				addr_q <= ADDR_W'(pos_q >> 3);
				cnt_q  <= CNT_W'(span);
				tail_q <= ~last_bit[2:0];
				elen_q <= len_q;
			end
		end else begin
			if (cmd.adv) begin
				addr_q <= addr_q + ADDR_W'(1);
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			if (cmd.wr_merge) begin
				dwin_q <= dwin_q << 8;
				mwin_q <= mwin_q << 8;
			end
			if (rd_s1 && kind_d == K_GET) begin
				acc_q <= {acc_q[ACC_BITS-9:0], rbyte};
			end
			if (cmd.extract) begin
				res_q <= acc_sh[63:0] & emask;
			end else if (cmd.sign && sgn_q && res_q[sbit]) begin
				res_q <= res_q | ~emask;
			end
		end
		if (cmd.rd) begin
			rvalid_s1 <= valid_q[addr_q];
		end
		if (cmd.load_out) begin
			out_data_q <= res_q;
			out_err_q  <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
		end
	end

	assign read_value = out_data_q;
	assign error      = out_err_q;

endmodule

/* hw/rtl/bfei_ctrl.sv */
// Controller: sequences one item through decode, byte reads, merges and result hand-off.
// Depends on bfei_pkg; commands bfei_dp through cmd_t and watches sts_t.
module bfei_ctrl
	import bfei_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		IDLE,
		SETUP,
		GET_RD,
		GET_WAIT,
		EXTRACT,
		SIGN,
		SET_RD,
		SET_WR,
		WR_BYTE,
		DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == IDLE) && s_tvalid;
		cmd.setup    = (state_q == SETUP);
		cmd.rd       = (state_q == GET_RD) || (state_q == SET_RD);
		cmd.adv      = (state_q == GET_RD) || (state_q == SET_WR);
		cmd.wr_byte  = (state_q == WR_BYTE);
		cmd.wr_merge = (state_q == SET_WR);
		cmd.extract  = (state_q == EXTRACT);
		cmd.sign     = (state_q == SIGN);
		cmd.load_out = (state_q == DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= SETUP;
					end
				end
				SETUP: begin
					if (sts.err) begin
						state_q <= DONE;
					end else begin
						unique case (sts.kind)
							K_WRITE: state_q <= WR_BYTE;
							K_GET:   state_q <= GET_RD;
							K_SET:   state_q <= SET_RD;
							default: state_q <= DONE;
						endcase
					end
				end
				GET_RD: begin
					if (sts.last) begin
						state_q <= GET_WAIT;
					end
				end
				GET_WAIT: state_q <= EXTRACT;
				EXTRACT:  state_q <= SIGN;
				SIGN:     state_q <= DONE;
				SET_RD:   state_q <= SET_WR;
				SET_WR: begin
					state_q <= sts.last ? DONE : SET_RD;
				end
				WR_BYTE: state_q <= DONE;
				DONE: begin
					if (slot_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Single RAM port: never read and write in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && (cmd.wr_byte || cmd.wr_merge)))
		else $error("buffer read and write in the same cycle");

	// A merged write uses the byte read in the cycle before
	a_merge_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_merge |-> $past(cmd.rd))
		else $error("merge write without a preceding read");

	// Never overwrite a result that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.load_out)
		else $error("result overwritten while stalled");

	// A rejected request skips all buffer traffic
	a_err_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SETUP && sts.err) |=> (state_q == DONE))
		else $error("rejected request touched the buffer");

endmodule

/* hw/rtl/bit_field_extract_insert.sv */
// Top level of the MSB-first bit field extract/insert block.
// Depends on bfei_pkg, bfei_ram, bfei_dp and bfei_ctrl.
//
// Usage:
//   Slave channel s_*: one item per operation. s_tuser carries the opcode
//   (write byte, read byte, get unsigned, get signed, set field); s_tdata
//   carries the operands. Master channel m_*: exactly one result per item,
//   m_tdata is the 64-bit read value, m_tuser the error flag.
//   Items are processed one at a time. The buffer RAM has a single byte
//   port, so the bytes of an item are read and written one after another:
//     get / read byte spanning n bytes (n = 1..9): one read per byte
//     set spanning n bytes (n = 1..5): one read and one write per byte
//     write byte: one write; rejected or unused opcode: no buffer access
//   The result appears on m_tvalid in the cycle that s_tready rises again.
//   A new item is accepted while a result still waits on the master side;
//   if the receiver stalls, the following item halts at its result hand-off.
//   Reset clears the control state and per-byte valid flags, so the whole
//   buffer reads as zero right after reset with no clearing pass.
module bit_field_extract_insert
	import bfei_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // byte_index[7:0], byte_value[15:8], bit_pos[26:16],
	                               // field_len[33:27], set_value[65:34], zero[71:66]
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // read_value[63:0]
	output logic [0:0]  m_tuser    // error[0]
);

	cmd_t              cmd;
	sts_t              sts;
	logic              ram_re;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	bfei_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfei_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (s_tuser),
		.byte_index (s_tdata[7:0]),
		.byte_value (s_tdata[15:8]),
		.bit_pos    (s_tdata[26:16]),
		.field_len  (s_tdata[33:27]),
		.set_value  (s_tdata[65:34]),
		.ram_re     (ram_re),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.read_value (m_tdata),
		.error      (m_tuser[0])
	);

	bfei_ram #(
		.WIDTH (8),
		.DEPTH (BUF_BYTES)
	) u_buf (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule
